// File: src/imu_offset_noise_calibrator_core_defines.svh
// Assertion macros for the IMU offset and noise calibrator.
`ifndef IMU_OFFSET_NOISE_CALIBRATOR_CORE_DEFINES_SVH
`define IMU_OFFSET_NOISE_CALIBRATOR_CORE_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define IMU_CAL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked check that also runs through reset.
`define IMU_CAL_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: src/imu_cal_pkg.sv
// Shared types and constants of the IMU offset and noise calibrator.
package imu_cal_pkg;

    localparam int NUM_CH    = 6;
    localparam int NUM_ACC   = 3;
    localparam int CH_W      = 3;
    localparam int FILT_AW   = 2;
    localparam int RAW_W     = 16;
    localparam int COR_W     = 17;
    localparam int NOISE_W   = 16;
    localparam int SUM_W     = 26;
    localparam int PEAK_W    = SUM_W;
    localparam int FILT_W    = SUM_W + 1;
    localparam int CAL_W     = 11;
    localparam int CNT_W     = 10;
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = 5;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 200;

    localparam logic [CAL_W-1:0] CAL_RESET = 11'd100;
    localparam logic [CAL_W-1:0] CAL_MAX   = 11'd1024;

    typedef enum logic [1:0] {
        PH_AVG,
        PH_NOISE,
        PH_RUN
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MOD,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] acc;
        logic [PEAK_W-1:0]       noise;
    } cal_word_t;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CAL_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: src/imu_cal_ram.sv
// Generic single-port RAM with registered read.
module imu_cal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/imu_cal_div.sv
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
module imu_cal_div import imu_cal_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [CAL_W-1:0]     rem_reg, rem_next;
    logic [CAL_W-1:0]     den_reg, den_next;

    logic [SUM_W-1:0]     mag;
    logic [CAL_W-1:0]     rem_shift;
    logic [CAL_W:0]       trial;

    always_comb begin
        mag       = req.dividend[SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;
        rem_shift = {rem_reg[CAL_W-2:0], quo_reg[SUM_W-1]};
        trial     = {1'b0, rem_shift} - {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;

        if (req.start) begin
            busy_next = 1'b1;
            neg_next  = req.dividend[SUM_W-1];
            cnt_next  = '0;
            quo_next  = mag;
            rem_next  = '0;
            den_next  = req.divisor;
        end else if (busy_reg) begin
            if (!trial[CAL_W]) begin
                rem_next = trial[CAL_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// File: src/imu_offset_noise_calibrator_core.sv
// IMU offset and noise calibrator: top level. After reset the first cal_samples
// words are averaged per axis into offsets and the next cal_samples words set the
// per-axis peak deviation; neither phase returns a word. Afterwards every input
// word returns one word with offset-corrected gyro, low-passed accel and the six
// noise peaks. Items are handled one at a time, walking the six channels through a
// read and, while calibrating, a write-back of the calibration RAM; in the run phase
// the result then loads the output register. In the last averaging item each axis
// offset passes through the 26-step bit-serial divider. A finished result waits in
// the output register while the next word is taken; the user must write cal_samples
// only while the block is idle, and the block itself does not enforce this.
module imu_offset_noise_calibrator_core import imu_cal_pkg::*; #(
    parameter int AXES = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CAL_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // raw_accel_x, raw_accel_y, raw_accel_z, raw_gyro_x, raw_gyro_y, raw_gyro_z
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // filt_accel_x/y/z, corr_gyro_x/y/z, noise_accel_x/y/z, noise_gyro_x/y/z, pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CAL_AW = (AXES > 1) ? $clog2(AXES) : 1;

    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CH_W-1:0]         axis_reg, axis_next;
    logic                    filt_started_reg, filt_started_next;
    logic [CAL_W-1:0]        cal_samples_reg;
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    logic signed [RAW_W-1:0]   raw_reg [NUM_CH];
    logic signed [COR_W-1:0]   res_filt_reg [NUM_ACC];
    logic signed [COR_W-1:0]   res_gyro_reg [NUM_ACC];
    logic [NOISE_W-1:0]        res_noise_reg [NUM_CH];

    logic                    capture, res_load, out_load, step_done;
    logic                    cal_we, filt_we;
    logic [CAL_AW-1:0]       cal_addr;
    logic [FILT_AW-1:0]      filt_addr;
    cal_word_t               cal_wdata, cal_rd;
    logic signed [FILT_W-1:0] filt_rd;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    logic [CAL_W-1:0]        n_eff, count_inc;
    logic                    last_item, axis_cal, axis_acc;
    logic signed [RAW_W-1:0] raw_cur;
    logic signed [SUM_W-1:0] off;
    logic signed [SUM_W-1:0] sum_base, sum_new;
    logic signed [FILT_W-1:0] diff, filt_base, fnew;
    logic [FILT_W-1:0]       abs_d;
    logic [PEAK_W-1:0]       noise_cand, noise_base, noise_new;
    logic [NOISE_W-1:0]      noise_out;
    logic [FILT_W:0]         fsum, fadj;
    logic [FILT_AW-1:0]      gyro_idx;
    logic [M_TDATA_W-1:0]    out_word;

    imu_cal_ram #(
        .WIDTH ($bits(cal_word_t)),
        .DEPTH (AXES)
    ) u_cal_ram (
        .aclk  (aclk),
        .we    (cal_we),
        .addr  (cal_addr),
        .wdata (cal_wdata),
        .rdata (cal_rd)
    );

    imu_cal_ram #(
        .WIDTH (FILT_W),
        .DEPTH (NUM_ACC)
    ) u_filt_ram (
        .aclk  (aclk),
        .we    (filt_we),
        .addr  (filt_addr),
        .wdata (fnew),
        .rdata (filt_rd)
    );

    imu_cal_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // datapath
    always_comb begin
        if (cal_samples_reg == '0) begin
            n_eff = CAL_W'(1);
        end else if (cal_samples_reg > CAL_MAX) begin
            n_eff = CAL_MAX;
        end else begin
            n_eff = cal_samples_reg;
        end
        count_inc = {1'b0, count_reg} + CAL_W'(1);
        last_item = (count_inc >= n_eff);

        axis_cal  = (int'(axis_reg) < AXES);
        axis_acc  = (axis_reg < CH_W'(NUM_ACC));
        cal_addr  = axis_cal ? axis_reg[CAL_AW-1:0] : '0;
        filt_addr = axis_acc ? axis_reg[FILT_AW-1:0] : '0;
        gyro_idx  = FILT_AW'(axis_reg - CH_W'(NUM_ACC));

        raw_cur  = raw_reg[axis_reg];
        sum_base = (count_reg == '0) ? '0 : cal_rd.acc;
        sum_new  = sum_base + {{(SUM_W-RAW_W){raw_cur[RAW_W-1]}}, raw_cur};

        // offset may exceed 16 bits when cal_samples is lowered mid-phase
        off   = axis_cal ? cal_rd.acc : '0;
        diff  = {{(FILT_W-RAW_W){raw_cur[RAW_W-1]}}, raw_cur} - {off[SUM_W-1], off};
        abs_d = diff[FILT_W-1] ? (~diff + 1'b1) : diff;

        noise_cand = abs_d[PEAK_W-1:0];
        noise_base = (count_reg == '0) ? '0 : cal_rd.noise;
        noise_new  = (noise_cand > noise_base) ? noise_cand : noise_base;
        noise_out  = axis_cal ? cal_rd.noise[NOISE_W-1:0] : '0;

        // (prev + corrected) / 2, truncated toward zero
        filt_base = filt_started_reg ? filt_rd : '0;
        fsum      = {filt_base[FILT_W-1], filt_base} + {diff[FILT_W-1], diff};
        fadj      = fsum + {{FILT_W{1'b0}}, fsum[FILT_W]};
        fnew      = fadj[FILT_W:1];

        out_word = '0;
        for (int i = 0; i < NUM_ACC; i++) begin
            out_word[i*COR_W +: COR_W]             = res_filt_reg[i];
            out_word[(NUM_ACC+i)*COR_W +: COR_W]   = res_gyro_reg[i];
        end
        for (int i = 0; i < NUM_CH; i++) begin
            out_word[NUM_CH*COR_W + i*NOISE_W +: NOISE_W] = res_noise_reg[i];
        end
    end

    // sequencer
    always_comb begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        count_next        = count_reg;
        axis_next         = axis_reg;
        filt_started_next = filt_started_reg;
        s_tready          = 1'b0;
        capture           = 1'b0;
        res_load          = 1'b0;
        out_load          = 1'b0;
        step_done         = 1'b0;
        cal_we            = 1'b0;
        filt_we           = 1'b0;
        cal_wdata.acc     = sum_new;
        cal_wdata.noise   = cal_rd.noise;
        div_req.start     = 1'b0;
        div_req.dividend  = sum_new;
        div_req.divisor   = n_eff;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    capture    = 1'b1;
                    axis_next  = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_MOD;
            end
            ST_MOD: begin
                case (phase_reg)
                    PH_AVG: begin
                        if (axis_cal && last_item) begin
                            div_req.start = 1'b1;
                            state_next    = ST_DIV;
                        end else begin
                            cal_we    = axis_cal;
                            step_done = 1'b1;
                        end
                    end
                    PH_NOISE: begin
                        cal_we          = axis_cal;
                        cal_wdata.acc   = cal_rd.acc;
                        cal_wdata.noise = noise_new;
                        step_done       = 1'b1;
                    end
                    PH_RUN: begin
                        filt_we   = axis_acc;
                        res_load  = 1'b1;
                        step_done = 1'b1;
                    end
                    default: begin
                        step_done = 1'b1;
                    end
                endcase
            end
            ST_DIV: begin
                cal_wdata.acc   = div_rsp.quotient;
                cal_wdata.noise = '0;
                if (div_rsp.done) begin
                    cal_we    = 1'b1;
                    step_done = 1'b1;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (step_done) begin
            if (axis_reg == CH_W'(NUM_CH - 1)) begin
                axis_next  = '0;
                state_next = ST_IDLE;
                case (phase_reg)
                    PH_AVG: begin
                        if (last_item) begin
                            count_next = '0;
                            phase_next = PH_NOISE;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    PH_NOISE: begin
                        if (last_item) begin
                            count_next = '0;
                            phase_next = PH_RUN;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    default: begin
                        filt_started_next = 1'b1;
                        state_next        = ST_OUT;
                    end
                endcase
            end else begin
                axis_next  = axis_reg + 1'b1;
                state_next = ST_READ;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_AVG;
            count_reg        <= '0;
            axis_reg         <= '0;
            filt_started_reg <= 1'b0;
            cal_samples_reg  <= CAL_RESET;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            count_reg        <= count_next;
            axis_reg         <= axis_next;
            filt_started_reg <= filt_started_next;
            if (cfg_wr_en) begin
                cal_samples_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            for (int i = 0; i < NUM_CH; i++) begin
                raw_reg[i] <= s_tdata[i*RAW_W +: RAW_W];
            end
        end
        if (res_load) begin
            if (axis_acc) begin
                res_filt_reg[axis_reg[FILT_AW-1:0]] <= fnew[COR_W-1:0];
            end else begin
                res_gyro_reg[gyro_idx] <= diff[COR_W-1:0];
            end
            res_noise_reg[axis_reg] <= noise_out;
        end
        if (out_load) begin
            m_tdata_reg <= out_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: src/imu_cal_checker.sv
// Port-level checks for the IMU offset and noise calibrator, bound to the top level.
`include "imu_offset_noise_calibrator_core_defines.svh"

module imu_cal_checker import imu_cal_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `IMU_CAL_ASSERT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result word dropped while stalled")
    `IMU_CAL_ASSERT(a_m_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "result word changed while stalled")
    `IMU_CAL_ASSERT(a_one_item, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input taken while an item is in work")
    `IMU_CAL_ASSERT_RST(a_rst_quiet, aclk, !aresetn |=> !m_tvalid && s_tready, "block not idle after reset")

endmodule

bind imu_offset_noise_calibrator_core imu_cal_checker u_imu_cal_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for imu_offset_noise_calibrator_core: predicts every output word.
module tb;
    import imu_cal_pkg::*;

    localparam int SETTLE_CYC = 400;
    localparam int RUN_WORDS  = 500;
    localparam int CALM_WORDS = 80;
    localparam int PAD_LSB    = NUM_CH * (COR_W + NOISE_W);

    class imu_cal_scoreboard;
        logic [CAL_W-1:0]     cal_samples;
        phase_t               phase;
        int                   sample_cnt;
        longint               axis_sum [NUM_CH];
        int                   axis_off [NUM_CH];
        int                   axis_peak[NUM_CH];
        int                   accel_lp [NUM_ACC];
        string                field_name[2*NUM_CH];
        logic [M_TDATA_W-1:0] pending_words[$];
        int                   errors;

        function new();
            cal_samples = CAL_RESET;
            phase       = PH_AVG;
            sample_cnt  = 0;
            errors      = 0;
            for (int i = 0; i < NUM_CH; i++) begin
                axis_sum[i]  = 0;
                axis_off[i]  = 0;
                axis_peak[i] = 0;
            end
            for (int i = 0; i < NUM_ACC; i++) begin
                accel_lp[i] = 0;
            end
            field_name = '{"filt_accel_x", "filt_accel_y", "filt_accel_z",
                           "corr_gyro_x", "corr_gyro_y", "corr_gyro_z",
                           "noise_accel_x", "noise_accel_y", "noise_accel_z",
                           "noise_gyro_x", "noise_gyro_y", "noise_gyro_z"};
        endfunction

        function void set_cal_samples(input logic [CAL_W-1:0] v);
            cal_samples = v;
        endfunction

        function void note_sample(input logic [S_TDATA_W-1:0] w);
            int                   raw[NUM_CH];
            int                   n;
            int                   d;
            logic [M_TDATA_W-1:0] word;
            if (cal_samples == 0) begin
                n = 1;
            end else if (cal_samples > CAL_MAX) begin
                n = int'(CAL_MAX);
            end else begin
                n = int'(cal_samples);
            end
            for (int i = 0; i < NUM_CH; i++) begin
                raw[i] = int'($signed(w[i*RAW_W +: RAW_W]));
            end
            case (phase)
                PH_AVG: begin
                    for (int i = 0; i < NUM_CH; i++) begin
                        axis_sum[i] += raw[i];
                    end
                    sample_cnt++;
                    if (sample_cnt >= n) begin
                        for (int i = 0; i < NUM_CH; i++) begin
                            axis_off[i] = int'(axis_sum[i] / longint'(n));
                        end
                        sample_cnt = 0;
                        phase      = PH_NOISE;
                    end
                end
                PH_NOISE: begin
                    for (int i = 0; i < NUM_CH; i++) begin
                        d = raw[i] - axis_off[i];
                        if (d < 0) d = -d;
                        if (d > axis_peak[i]) axis_peak[i] = d;
                    end
                    sample_cnt++;
                    if (sample_cnt >= n) begin
                        sample_cnt = 0;
                        phase      = PH_RUN;
                    end
                end
                default: begin
                    word = '0;
                    for (int i = 0; i < NUM_CH; i++) begin
                        d = raw[i] - axis_off[i];
                        if (i < NUM_ACC) begin
                            accel_lp[i] = (accel_lp[i] + d) / 2;
                            d = accel_lp[i];
                        end
                        word[i*COR_W +: COR_W] = d[COR_W-1:0];
                        word[NUM_CH*COR_W + i*NOISE_W +: NOISE_W] = axis_peak[i][NOISE_W-1:0];
                    end
                    pending_words.push_back(word);
                end
            endcase
        endfunction

        function void check_word(input logic [M_TDATA_W-1:0] got);
            logic [M_TDATA_W-1:0] want;
            int                   lsb;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected output word, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            for (int f = 0; f < 2*NUM_CH; f++) begin
                if (f < NUM_CH) begin
                    lsb = f * COR_W;
                    if (got[lsb +: COR_W] !== want[lsb +: COR_W]) begin
                        $display("%0t: %s expected %0d actual %0d", $time, field_name[f],
                                 $signed(want[lsb +: COR_W]), $signed(got[lsb +: COR_W]));
                        errors++;
                    end
                end else begin
                    lsb = NUM_CH*COR_W + (f - NUM_CH)*NOISE_W;
                    if (got[lsb +: NOISE_W] !== want[lsb +: NOISE_W]) begin
                        $display("%0t: %s expected %0d actual %0d", $time, field_name[f],
                                 want[lsb +: NOISE_W], got[lsb +: NOISE_W]);
                        errors++;
                    end
                end
            end
            if (got[M_TDATA_W-1:PAD_LSB] !== want[M_TDATA_W-1:PAD_LSB]) begin
                $display("%0t: pad expected %b actual %b", $time,
                         want[M_TDATA_W-1:PAD_LSB], got[M_TDATA_W-1:PAD_LSB]);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CAL_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    bit                   calm = 1'b0;

    imu_cal_scoreboard    sb;

    imu_offset_noise_calibrator_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic logic [S_TDATA_W-1:0] fill(input logic [RAW_W-1:0] v);
        return {NUM_CH{v}};
    endfunction

    function automatic logic [S_TDATA_W-1:0] rand_sample();
        logic [S_TDATA_W-1:0] w;
        for (int i = 0; i < NUM_CH; i++) begin
            case ($urandom_range(0, 9))
                0:       w[i*RAW_W +: RAW_W] = 16'h8000;
                1:       w[i*RAW_W +: RAW_W] = 16'h7fff;
                2:       w[i*RAW_W +: RAW_W] = RAW_W'($urandom_range(0, 64) - 32);
                default: w[i*RAW_W +: RAW_W] = RAW_W'($urandom);
            endcase
        end
        return w;
    endfunction

    task automatic send_word(input logic [S_TDATA_W-1:0] w);
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(w);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    // stop sending, let all results out, then give the block time to finish a silent word
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_cal(input logic [CAL_W-1:0] v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_cal_samples(v);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_word(m_tdata);
        end
    end

    initial begin
        m_tready = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        sb          = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // averaging: count beyond range clamps to 1024
        write_cal(11'd2047);
        send_word(fill(16'h8000));
        send_word(fill(16'h7fff));
        send_word(fill(16'h5555));
        send_word(fill(16'haaaa));
        drain();
        // zero acts as one; count already past it, so the next word closes averaging
        write_cal(11'd0);
        send_word(96'h1234_fedc_0abc_f00d_7ff0_8010);
        drain();

        // noise phase
        write_cal(CAL_MAX);
        send_word(fill(16'h8000));
        send_word(fill(16'h7fff));
        send_word(fill(16'h0000));
        send_word(fill(16'hffff));
        drain();
        write_cal(11'd9);
        while (sb.phase != PH_RUN) send_word(rand_sample());

        // running
        send_word(fill(16'h8000));
        send_word(fill(16'h7fff));
        send_word(fill(16'h7fff));
        send_word(fill(16'h8000));
        send_word(fill(16'h0000));
        send_word(fill(16'hffff));
        send_word(96'h5555_aaaa_5555_aaaa_5555_aaaa);
        drain();
        write_cal(11'd1);

        for (int k = 0; k < RUN_WORDS; k++) begin
            if (k == RUN_WORDS / 2) begin
                drain();
                write_cal(CAL_W'($urandom_range(2, 2047)));
            end
            if (k == RUN_WORDS - CALM_WORDS) calm = 1'b1;
            send_word(rand_sample());
        end
        drain();

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout");
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/imu_cal_pkg.sv
src/imu_cal_ram.sv
src/imu_cal_div.sv
src/imu_offset_noise_calibrator_core.sv
src/imu_cal_checker.sv
sim/tb.sv
